// ===== rtl/core/risbk_pkg.sv =====
// Types and constants for the record insertion sort block.
// Used by every module under rtl/core; no dependencies.
package risbk_pkg;

  localparam int MAX_POINTS_DEF = 64;

  typedef struct packed {
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [31:0] sort_key;
    logic               last_point;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_key;
    logic               out_last;
    logic               dropped_points;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] k;
  } point_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } chain_ctl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

endpackage

// ===== rtl/core/record_insertion_sort_by_key.sv =====
// Stable insertion sort of point sets by key, built as two cell chains.
// Load: one point per cycle, each inserted in order on the cycle it is accepted; points
//   beyond MAX_POINTS are dropped and flagged. Emit: after the marked last point the block
//   drains, moving one sorted point per cycle into the output register while res_stall allows.
// Input stalls while a set is emitted; the next set loads while the final word waits.
// Reset (rst, synchronous) empties both chains and clears counts and the direction.
module record_insertion_sort_by_key import risbk_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_data,
  input  logic      pt_valid,
  output logic      pt_stall,
  input  in_word_t  pt_word,
  output logic      res_valid,
  input  logic      res_stall,
  output out_word_t res_word
);

  localparam int CW = $clog2(MAX_POINTS + 1);

  state_t     state;
  state_t     state_next;
  logic       sort_descending;
  logic       desc_l;
  logic       drop_l;
  logic       overflow_seen;
  logic [CW-1:0] count;
  logic [CW-1:0] left;
  chain_ctl_t ctl;
  point_t     new_pt;
  point_t     head_asc;
  point_t     head_desc;
  point_t     head_sel;
  logic       accept_in;
  logic       full;
  logic       close_set;
  logic       take_out;
  logic       load_out;

  assign new_pt    = '{x: pt_word.x_coord, y: pt_word.y_coord, k: pt_word.sort_key};
  assign accept_in = pt_valid && !pt_stall;
  assign full      = (count == CW'(MAX_POINTS));
  assign close_set = accept_in && pt_word.last_point;
  assign take_out  = res_valid && !res_stall;
  assign head_sel  = desc_l ? head_desc : head_asc;

  always_comb begin
    state_next = state;
    pt_stall   = 1'b1;
    load_out   = 1'b0;
    case (state)
      ST_LOAD: begin
        pt_stall = 1'b0;
        if (pt_valid && pt_word.last_point) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        load_out = !res_valid || take_out;
        if (load_out && left == CW'(1)) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  assign ctl.insert = accept_in && !full;
  assign ctl.shift  = load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_descending <= 1'b0;
      count           <= '0;
      left            <= '0;
      overflow_seen   <= 1'b0;
      desc_l          <= 1'b0;
      drop_l          <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        sort_descending <= cfg_data;
      end
      if (close_set) begin
        count         <= '0;
        left          <= full ? count : count + CW'(1);
        overflow_seen <= 1'b0;
        desc_l        <= sort_descending;
        drop_l        <= overflow_seen || full;
      end else begin
        if (ctl.insert) begin
          count <= count + CW'(1);
        end
        if (accept_in && full) begin
          overflow_seen <= 1'b1;
        end
        if (load_out) begin
          left <= left - CW'(1);
        end
      end
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (take_out) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_word.out_x          <= head_sel.x;
      res_word.out_y          <= head_sel.y;
      res_word.out_key        <= head_sel.k;
      res_word.out_last       <= (left == CW'(1));
      res_word.dropped_points <= drop_l;
    end
  end

  risbk_chain #(.MAX_POINTS(MAX_POINTS)) u_chain_asc (
    .clk    (clk),
    .rst    (rst),
    .desc   (1'b0),
    .ctl    (ctl),
    .new_pt (new_pt),
    .head   (head_asc)
  );

  risbk_chain #(.MAX_POINTS(MAX_POINTS)) u_chain_desc (
    .clk    (clk),
    .rst    (rst),
    .desc   (1'b1),
    .ctl    (ctl),
    .new_pt (new_pt),
    .head   (head_desc)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (left != '0))
    else $error("draining with no points left");

  a_last_ends_drain: assert property (@(posedge clk) disable iff (rst)
    (load_out && left == CW'(1)) |=> (state == ST_LOAD && res_valid && res_word.out_last))
    else $error("final word did not end the set");

endmodule

// ===== rtl/core/risbk_cell.sv =====
// One compare-and-shift cell of the sorting chain.
// Depends on risbk_pkg.
module risbk_cell import risbk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       desc,
  input  chain_ctl_t ctl,
  input  point_t     new_pt,
  input  logic       prev_valid,
  input  logic       prev_after,
  input  point_t     prev_pt,
  input  logic       next_valid,
  input  point_t     next_pt,
  output logic       valid,
  output logic       after,
  output point_t     pt
);

  logic displaced;

  assign after     = valid && (desc ? (pt.k < new_pt.k) : (pt.k > new_pt.k));
  assign displaced = !valid || after;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= next_valid;
    end else if (ctl.insert && displaced) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      pt <= next_pt;
    end else if (ctl.insert && displaced) begin
      pt <= (prev_valid && prev_after) ? prev_pt : new_pt;
    end
  end

endmodule

// ===== rtl/core/risbk_chain.sv =====
// Row of sorting cells: inserts a point per cycle on ctl.insert, in key order; shifts out toward cell 0.
// Depends on risbk_pkg and risbk_cell.
module risbk_chain import risbk_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       desc,
  input  chain_ctl_t ctl,
  input  point_t     new_pt,
  output point_t     head
);

  logic   valid [MAX_POINTS];
  logic   after [MAX_POINTS];
  point_t pts   [MAX_POINTS];

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    logic   p_valid;
    logic   p_after;
    point_t p_pt;
    logic   n_valid;
    point_t n_pt;

    if (i == 0) begin : g_first
      assign p_valid = 1'b1;
      assign p_after = 1'b0;
      assign p_pt    = new_pt;
    end else begin : g_mid
      assign p_valid = valid[i-1];
      assign p_after = after[i-1];
      assign p_pt    = pts[i-1];
    end

    if (i == MAX_POINTS - 1) begin : g_last
      assign n_valid = 1'b0;
      assign n_pt    = new_pt;
    end else begin : g_inner
      assign n_valid = valid[i+1];
      assign n_pt    = pts[i+1];
    end

    risbk_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .desc       (desc),
      .ctl        (ctl),
      .new_pt     (new_pt),
      .prev_valid (p_valid),
      .prev_after (p_after),
      .prev_pt    (p_pt),
      .next_valid (n_valid),
      .next_pt    (n_pt),
      .valid      (valid[i]),
      .after      (after[i]),
      .pt         (pts[i])
    );
  end

  assign head = pts[0];

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for record_insertion_sort_by_key: a directed table, then random point sets.
// Sorted words are predicted by a stable insertion sort kept in step with accepted points, or taken from the table.
// Depends on risbk_pkg and the RTL top only.
module tb;
  import risbk_pkg::*;

  localparam int CAP = MAX_POINTS_DEF;
  localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;
  localparam int ITEM_TARGET = 330;

  typedef enum logic {
    ROW_POINT,
    ROW_ORDER
  } row_kind_t;

  // flag: last_point on point rows, descending on order rows
  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] key;
    logic        flag;
    logic        typed;
    logic [31:0] wx;
    logic [31:0] wy;
    logic [31:0] wkey;
    logic        wlast;
    logic        wdrop;
  } row_t;

  localparam int ROWS = 23;
  localparam row_t SCRIPT [ROWS] = '{
    '{ROW_POINT, MAXV, MAXV, MAXV, 1'b1, 1'b1, MAXV, MAXV, MAXV, 1'b1, 1'b0},
    '{ROW_POINT, MINV, MINV, MINV, 1'b1, 1'b1, MINV, MINV, MINV, 1'b1, 1'b0},
    '{ROW_POINT, 0, 0, 0, 1'b1, 1'b1, 0, 0, 0, 1'b1, 1'b0},
    '{ROW_POINT, -1, 0, -1, 1'b1, 1'b1, -1, 0, -1, 1'b1, 1'b0},
    '{ROW_POINT, 1, 10, 5, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
    '{ROW_POINT, 2, 20, -3, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
    '{ROW_POINT, 3, 30, 5, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
    '{ROW_POINT, 4, 40, MINV, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
    '{ROW_POINT, 5, 50, MAXV, 1'b1, 1'b0, 0, 0, 0, 1'b0, 1'b0},
    '{ROW_ORDER, 0, 0, 0, 1'b1, 1'b0, 0, 0, 0, 1'b0, 1'b0},
    '{ROW_POINT, 11, 1, 7, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
    '{ROW_POINT, 12, 2, 7, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
    '{ROW_POINT, 13, 3, -7, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
    '{ROW_POINT, 14, 4, MAXV, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
    '{ROW_POINT, 15, 5, 7, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
    '{ROW_POINT, 16, 6, MINV, 1'b1, 1'b0, 0, 0, 0, 1'b0, 1'b0},
    '{ROW_POINT, 123, -456, 32'h0001_8000, 1'b1, 1'b1, 123, -456, 32'h0001_8000, 1'b1, 1'b0},
    '{ROW_POINT, 21, 0, MINV, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
    '{ROW_POINT, 22, 0, MINV, 1'b1, 1'b0, 0, 0, 0, 1'b0, 1'b0},
    '{ROW_ORDER, 0, 0, 0, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
    '{ROW_POINT, 31, 0, 3, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
    '{ROW_POINT, 32, 0, 2, 1'b0, 1'b0, 0, 0, 0, 1'b0, 1'b0},
    '{ROW_POINT, 33, 0, 1, 1'b1, 1'b0, 0, 0, 0, 1'b0, 1'b0}
  };

  logic      clk = 1'b0;
  logic      rst;
  logic      cfg_we;
  logic      cfg_data;
  logic      pt_valid;
  logic      pt_stall;
  in_word_t  pt_word;
  logic      res_valid;
  logic      res_stall;
  out_word_t res_word;

  point_t    held_pts [CAP];
  int        held_count = 0;
  bit        held_overflow = 1'b0;
  bit        order_desc = 1'b0;
  out_word_t sorted_pending [$];

  int errors = 0;
  int words_checked = 0;
  int points_in = 0;
  int sets_closed = 0;
  int sets_overflowed = 0;
  int rx_hold = 0;

  record_insertion_sort_by_key u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .pt_valid  (pt_valid),
    .pt_stall  (pt_stall),
    .pt_word   (pt_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    if (errors < 50) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    errors++;
  endtask

  function automatic void collect_point(input in_word_t w, input bit keep);
    point_t    cur;
    out_word_t res;
    int        j;
    if (held_count < CAP) begin
      held_pts[held_count] = '{w.x_coord, w.y_coord, w.sort_key};
      held_count++;
    end else begin
      held_overflow = 1'b1;
    end
    if (w.last_point) begin
      for (int i = 1; i < held_count; i++) begin
        cur = held_pts[i];
        j = i;
        while (j > 0 && (order_desc ? ($signed(held_pts[j-1].k) < $signed(cur.k))
                                    : ($signed(held_pts[j-1].k) > $signed(cur.k)))) begin
          held_pts[j] = held_pts[j-1];
          j--;
        end
        held_pts[j] = cur;
      end
      for (int i = 0; i < held_count; i++) begin
        res = '{held_pts[i].x, held_pts[i].y, held_pts[i].k, (i == held_count - 1),
                held_overflow};
        if (keep) begin
          sorted_pending.push_back(res);
        end
      end
      sets_closed++;
      if (held_overflow) begin
        sets_overflowed++;
      end
      held_count = 0;
      held_overflow = 1'b0;
    end
  endfunction

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (sorted_pending.size() == 0) begin
      flag_mismatch($sformatf("word %h with none expected", got));
    end else begin
      want = sorted_pending.pop_front();
      words_checked++;
      if (got.out_x !== want.out_x)
        flag_mismatch($sformatf("word %0d out_x %h, want %h", words_checked, got.out_x,
                                want.out_x));
      if (got.out_y !== want.out_y)
        flag_mismatch($sformatf("word %0d out_y %h, want %h", words_checked, got.out_y,
                                want.out_y));
      if (got.out_key !== want.out_key)
        flag_mismatch($sformatf("word %0d out_key %h, want %h", words_checked, got.out_key,
                                want.out_key));
      if (got.out_last !== want.out_last)
        flag_mismatch($sformatf("word %0d out_last %b, want %b", words_checked, got.out_last,
                                want.out_last));
      if (got.dropped_points !== want.dropped_points)
        flag_mismatch($sformatf("word %0d dropped_points %b, want %b", words_checked,
                                got.dropped_points, want.dropped_points));
    end
  endtask

  task automatic send_point(input in_word_t w, input bit burst, input bit keep);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      pt_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pt_valid <= 1'b1;
    pt_word  <= w;
    do @(posedge clk); while (pt_stall);
    points_in++;
    collect_point(w, keep);
  endtask

  task automatic wait_sets_out();
    pt_valid <= 1'b0;
    while (sorted_pending.size() != 0) @(posedge clk);
  endtask

  task automatic set_order(input bit desc);
    wait_sets_out();
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= desc;
    @(posedge clk);
    cfg_we   <= 1'b0;
    order_desc = desc;
  endtask

  function automatic logic signed [31:0] pick_key();
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 4))
        0: return MINV;
        1: return MAXV;
        2: return 0;
        3: return -1;
        default: return 1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic send_set(input int n, input bit burst);
    in_word_t w;
    for (int i = 0; i < n; i++) begin
      w.x_coord    = $urandom;
      w.y_coord    = $urandom;
      w.sort_key   = pick_key();
      w.last_point = (i == n - 1);
      send_point(w, burst, 1'b1);
    end
  endtask

  initial begin
    int rx_wait;
    bit rx_burst;
    rx_wait = 0;
    rx_burst = 1'b0;
    res_stall <= 1'b1;
    do @(posedge clk); while (rst);
    forever begin
      if (res_valid && !res_stall) begin
        check_word(res_word);
        if ($urandom_range(0, 15) == 0) begin
          rx_burst = !rx_burst;
        end
        rx_wait = rx_burst ? 0 : $urandom_range(0, 3);
      end
      if (rx_hold > 0) begin
        rx_wait = rx_hold;
        rx_hold = 0;
      end
      if (rx_wait > 0) begin
        res_stall <= 1'b1;
        rx_wait--;
      end else begin
        res_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  initial begin
    in_word_t  w;
    out_word_t want;
    int        n;
    int        set_no;
    rst      <= 1'b1;
    cfg_we   <= 1'b0;
    cfg_data <= 1'b0;
    pt_valid <= 1'b0;
    pt_word  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].kind == ROW_ORDER) begin
        set_order(SCRIPT[i].flag);
      end else begin
        w = '{SCRIPT[i].x, SCRIPT[i].y, SCRIPT[i].key, SCRIPT[i].flag};
        send_point(w, 1'b0, !SCRIPT[i].typed);
        if (SCRIPT[i].typed) begin
          want = '{SCRIPT[i].wx, SCRIPT[i].wy, SCRIPT[i].wkey, SCRIPT[i].wlast,
                   SCRIPT[i].wdrop};
          sorted_pending.push_back(want);
        end
      end
    end

    set_order(1'($urandom_range(0, 1)));
    send_set(CAP, 1'b0);
    send_set(CAP + 1, 1'b0);

    // hold the result side long enough that the input backs up
    wait_sets_out();
    rx_hold = 250;
    send_set(3, 1'b1);
    send_set(5, 1'b1);
    wait_sets_out();

    set_no = 0;
    while (points_in < ITEM_TARGET) begin
      if (set_no % 4 == 0) begin
        set_order(1'($urandom_range(0, 1)));
      end
      case ($urandom_range(0, 19))
        0: n = CAP + $urandom_range(0, 4);
        1, 2, 3: n = $urandom_range(9, 40);
        default: n = $urandom_range(1, 8);
      endcase
      send_set(n, $urandom_range(0, 3) == 0);
      set_no++;
    end

    wait_sets_out();
    repeat (20) @(posedge clk);
    $display("Covered %0d points in %0d sets (%0d over capacity) in both orders,",
             points_in, sets_closed, sets_overflowed);
    $display("with %0d sorted words checked and %0d mismatches.", words_checked, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d words still expected", sorted_pending.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/risbk_pkg.sv
rtl/core/risbk_cell.sv
rtl/core/risbk_chain.sv
rtl/core/record_insertion_sort_by_key.sv
sim/tb.sv
